// ===== sv/hsc_pkg.sv =====
`default_nettype none

package hsc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned SeqLen = 6;

  localparam logic [3:0] MaxDuty = 4'd8;
  localparam logic [7:0] SyncEdges = 8'd2;
  localparam logic [7:0] ReleaseSteps = 8'd2;

  // floor(x / 100) == (x * Recip100) >> Recip100Shift for every x below 2**20
  localparam int unsigned Recip100Shift = 26;
  localparam logic [19:0] Recip100 = 20'd671089;

  localparam logic [3:0] RunDutyRst = 4'd7;
  localparam logic [3:0] KickDutyRst = 4'd6;
  localparam logic [2:0] PhaseOffsetRst = 3'd3;
  localparam logic ReverseRst = 1'b0;
  localparam logic [15:0] TimerPeriodRst = 16'd4199;
  localparam logic [15:0] KickIntervalRst = 16'd600;
  localparam logic [7:0] KickStepLimitRst = 8'd40;

  localparam logic [2:0] OrderFwd [SeqLen] = '{3'd5, 3'd1, 3'd3, 3'd2, 3'd6, 3'd4};
  localparam logic [2:0] OrderAlt [SeqLen] = '{3'd5, 3'd4, 3'd6, 3'd2, 3'd3, 3'd1};

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RUN_DUTY,
    CFG_KICK_DUTY,
    CFG_PHASE_OFFSET,
    CFG_REVERSE,
    CFG_TIMER_PERIOD,
    CFG_KICK_INTERVAL,
    CFG_KICK_STEP_LIMIT
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_ENABLE,
    KIND_DISABLE
  } kind_e;

  typedef enum logic [1:0] {
    MODE_OFF,
    MODE_LOW,
    MODE_PWM
  } mode_e;

  typedef struct packed {
    mode_e u;
    mode_e v;
    mode_e w;
  } modes_t;

  typedef struct packed {
    logic [3:0]  run_duty;
    logic [3:0]  kick_duty;
    logic [2:0]  phase_offset;
    logic        reverse;
    logic [15:0] kick_interval;
    logic [7:0]  kick_step_limit;
    logic [15:0] pulse_run;
    logic [15:0] pulse_kick;
  } cfg_t;

  // period * duty by shift and add (duty is at most 8), then a constant
  // reciprocal multiply for the division by 100.
  function automatic logic [15:0] scale_pulse(logic [15:0] period, logic [3:0] duty);
    logic [19:0] prod;
    logic [39:0] full;
    prod = 20'd0;
    for (int k = 0; k < 4; k++) begin
      if (duty[k]) begin
        prod = prod + (20'(period) << k);
      end
    end
    full = 40'(prod) * 40'(Recip100);
    return 16'(full >> Recip100Shift);
  endfunction

  localparam logic [15:0] PulseRunRst = scale_pulse(TimerPeriodRst, RunDutyRst);
  localparam logic [15:0] PulseKickRst = scale_pulse(TimerPeriodRst, KickDutyRst);

  function automatic logic [2:0] order_code(logic rev, logic [2:0] idx);
    return rev ? OrderFwd[idx] : OrderAlt[idx];
  endfunction

  function automatic logic [2:0] position_of(logic rev, logic [2:0] code);
    logic [2:0] pos;
    pos = 3'd0;
    for (int i = 0; i < SeqLen; i++) begin
      if (order_code(rev, 3'(i)) == code) begin
        pos = 3'(i);
      end
    end
    return pos;
  endfunction

  function automatic logic code_invalid(logic [2:0] code);
    return (code == 3'd0) || (code == 3'd7);
  endfunction

  function automatic logic [2:0] remap(logic rev, logic [2:0] offset, logic [2:0] code);
    logic [3:0] sum;
    sum = {1'b0, position_of(rev, code)} + {1'b0, offset};
    if (sum >= 4'(SeqLen)) begin
      sum = sum - 4'(SeqLen);
    end
    return code_invalid(code) ? code : order_code(rev, sum[2:0]);
  endfunction

  function automatic modes_t drive_modes(logic [2:0] code);
    modes_t m;
    unique case (code)
      3'd1: m = '{u: MODE_PWM, v: MODE_OFF, w: MODE_LOW};
      3'd2: m = '{u: MODE_LOW, v: MODE_PWM, w: MODE_OFF};
      3'd3: m = '{u: MODE_OFF, v: MODE_PWM, w: MODE_LOW};
      3'd4: m = '{u: MODE_LOW, v: MODE_OFF, w: MODE_PWM};
      3'd5: m = '{u: MODE_PWM, v: MODE_LOW, w: MODE_OFF};
      3'd6: m = '{u: MODE_OFF, v: MODE_LOW, w: MODE_PWM};
      default: m = '{u: MODE_OFF, v: MODE_OFF, w: MODE_OFF};
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== sv/hall_six_step_commutator.sv =====
// Six-step commutator driven by Hall sensor codes.
// Input channel (in_valid_i / in_ready_o) carries one item per control event:
// a tick, an enable or a disable request, each with the raw Hall code.
// Output channel (out_valid_o / out_ready_i) returns exactly one result item
// per input item: the three phase modes, the PWM compare value, the bridge
// enable, fault, sector, kick status, counters and the run flag.
// Each result is registered before it is offered, and the block takes one item
// every cycle while in_ready_o is high; the whole step is a single pass of
// lookup and compare logic from the state register back into it.
// A two-entry result buffer sits on the output: while the receiver stalls,
// one more item is accepted and then in_ready_o drops until a result leaves.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at the
// clock edge; the duty-scaled compare values are computed at that write.
// Reset loads the default register values, turns the drive and bridge off,
// clears the counters and empties the result buffer.

`default_nettype none

module hall_six_step_commutator
  import hsc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire logic [1:0]          kind_i,
  input  wire logic [2:0]          hall_code_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      logic [1:0]          mode_u_o,
  output      logic [1:0]          mode_v_o,
  output      logic [1:0]          mode_w_o,
  output      logic [15:0]         pulse_width_o,
  output      logic                outputs_on_o,
  output      logic                hall_fault_o,
  output      logic [2:0]          sector_o,
  output      logic                kicking_o,
  output      logic [31:0]         edge_total_o,
  output      logic [31:0]         tick_total_o,
  output      logic                running_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam logic [3:0] PrevNone = 4'd8;

  typedef struct packed {
    logic        run;
    logic        kick;
    logic        rel_pend;
    logic        bridge;
    logic        fault;
    logic [3:0]  prev;
    logic [2:0]  kpos;
    logic [15:0] kdiv;
    logic [7:0]  ksteps;
    logic [7:0]  kedges;
    modes_t      modes;
    logic [15:0] pulse;
    logic [2:0]  sector;
    logic [31:0] edges;
    logic [31:0] ticks;
  } st_t;

  typedef struct packed {
    modes_t      modes;
    logic [15:0] pulse;
    logic        bridge;
    logic        fault;
    logic [2:0]  sector;
    logic        kick;
    logic [31:0] edges;
    logic [31:0] ticks;
    logic        run;
  } res_t;

  cfg_t cfg;

  hsc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  function automatic st_t commutate(st_t s, logic [2:0] code, cfg_t c);
    st_t r;
    r = s;
    if (code_invalid(code)) begin
      r.fault = 1'b1;
    end else begin
      r.modes = drive_modes(code);
      r.pulse = s.kick ? c.pulse_kick : c.pulse_run;
      r.fault = 1'b0;
      r.sector = position_of(c.reverse, code);
    end
    return r;
  endfunction

  function automatic st_t release_drive(st_t s, logic [2:0] hall, cfg_t c);
    st_t r;
    r = s;
    if (s.rel_pend) begin
      r.rel_pend = 1'b0;
      r.bridge = 1'b1;
      r = commutate(r, remap(c.reverse, c.phase_offset, hall), c);
    end
    return r;
  endfunction

  st_t  st_q, st_d;
  logic accept;
  logic edge_seen;
  res_t res_d;

  logic out_valid_q, skid_valid_q;
  res_t out_q, skid_q;
  logic pop;

  assign accept = in_valid_i && in_ready_o;
  assign pop = out_valid_q && out_ready_i;
  assign in_ready_o = !skid_valid_q;

  always_comb begin
    st_d = st_q;
    edge_seen = 1'b0;
    if (accept) begin
      unique case (kind_e'(kind_i))
        KIND_ENABLE: begin
          st_d.rel_pend = 1'b1;
          st_d.bridge = 1'b0;
          st_d.modes = '{u: MODE_OFF, v: MODE_OFF, w: MODE_OFF};
          st_d.run = 1'b1;
          st_d.edges = '0;
          st_d.ticks = '0;
          st_d.kick = 1'b1;
          st_d.kpos = position_of(cfg.reverse, hall_code_i);
          st_d.kdiv = '0;
          st_d.ksteps = '0;
          st_d.kedges = '0;
          st_d.prev = {1'b0, hall_code_i};
          st_d = commutate(st_d, remap(cfg.reverse, cfg.phase_offset, hall_code_i), cfg);
        end
        KIND_DISABLE: begin
          st_d.run = 1'b0;
          st_d.kick = 1'b0;
          st_d.rel_pend = 1'b0;
          st_d.bridge = 1'b0;
          st_d.modes = '{u: MODE_OFF, v: MODE_OFF, w: MODE_OFF};
        end
        KIND_TICK: begin
          if (st_q.run) begin
            if ({1'b0, hall_code_i} != st_q.prev) begin
              st_d.edges = st_q.edges + 32'd1;
              if (st_q.kick && st_q.kedges != 8'hFF) begin
                st_d.kedges = st_q.kedges + 8'd1;
              end
              st_d.prev = {1'b0, hall_code_i};
              edge_seen = 1'b1;
            end
            if (st_q.kick) begin
              st_d.kdiv = st_q.kdiv + 16'd1;
              if (st_d.kdiv >= cfg.kick_interval) begin
                // Forced open-loop step to the next sequence position.
                st_d.kdiv = '0;
                st_d.kpos = (st_q.kpos == 3'(SeqLen - 1)) ? 3'd0 : st_q.kpos + 3'd1;
                if (st_q.ksteps != 8'hFF) begin
                  st_d.ksteps = st_q.ksteps + 8'd1;
                end
                st_d = commutate(st_d, remap(cfg.reverse, cfg.phase_offset,
                                             order_code(cfg.reverse, st_d.kpos)), cfg);
                if (st_d.kedges >= SyncEdges || st_d.ksteps >= cfg.kick_step_limit) begin
                  st_d.kick = 1'b0;
                  st_d = release_drive(st_d, hall_code_i, cfg);
                end
              end
              if (st_d.rel_pend &&
                  (st_d.ksteps >= ReleaseSteps || st_d.kedges != 8'd0)) begin
                st_d = release_drive(st_d, hall_code_i, cfg);
              end
            end else if (edge_seen) begin
              st_d = release_drive(st_d, hall_code_i, cfg);
              st_d = commutate(st_d, remap(cfg.reverse, cfg.phase_offset, hall_code_i),
                               cfg);
            end
            st_d.ticks = st_q.ticks + 32'd1;
          end
        end
        default: ;
      endcase
    end
    res_d = '{modes: st_d.modes, pulse: st_d.pulse, bridge: st_d.bridge,
              fault: st_d.fault, sector: st_d.sector, kick: st_d.kick,
              edges: st_d.edges, ticks: st_d.ticks, run: st_d.run};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{run: 1'b0, kick: 1'b0, rel_pend: 1'b0, bridge: 1'b0, fault: 1'b0,
                prev: PrevNone, kpos: 3'd0, kdiv: 16'd0, ksteps: 8'd0, kedges: 8'd0,
                modes: '{u: MODE_OFF, v: MODE_OFF, w: MODE_OFF}, pulse: 16'd0,
                sector: 3'd0, edges: 32'd0, ticks: 32'd0};
    end else begin
      st_q <= st_d;
    end
  end

  // Two-entry result buffer: the skid entry only fills while the head waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= accept;
        end
      end else if (!out_valid_q) begin
        out_valid_q <= accept;
      end else if (accept) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && skid_valid_q) begin
      out_q <= skid_q;
    end else if ((pop || !out_valid_q) && accept) begin
      out_q <= res_d;
    end
    if (!pop && out_valid_q && accept) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign mode_u_o = out_q.modes.u;
  assign mode_v_o = out_q.modes.v;
  assign mode_w_o = out_q.modes.w;
  assign pulse_width_o = out_q.pulse;
  assign outputs_on_o = out_q.bridge;
  assign hall_fault_o = out_q.fault;
  assign sector_o = out_q.sector;
  assign kicking_o = out_q.kick;
  assign edge_total_o = out_q.edges;
  assign tick_total_o = out_q.ticks;
  assign running_o = out_q.run;

endmodule

`default_nettype wire

// ===== sv/hsc_cfg.sv =====
`default_nettype none

module hsc_cfg
  import hsc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                     cfg_o
);

  cfg_t        cfg_q, cfg_d;
  logic [15:0] period_q, period_d;
  logic [3:0]  duty_w;
  logic [2:0]  off_w;

  always_comb begin
    duty_w = (cfg_wdata_i[3:0] > MaxDuty) ? MaxDuty : cfg_wdata_i[3:0];
    off_w = (cfg_wdata_i[2:0] >= 3'(SeqLen)) ? cfg_wdata_i[2:0] - 3'(SeqLen)
                                              : cfg_wdata_i[2:0];
    cfg_d = cfg_q;
    period_d = period_q;
    if (cfg_we_i) begin
      // The pulse compare values are kept ready so an item never waits on them.
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_RUN_DUTY: begin
          cfg_d.run_duty = duty_w;
          cfg_d.pulse_run = scale_pulse(period_q, duty_w);
        end
        CFG_KICK_DUTY: begin
          cfg_d.kick_duty = duty_w;
          cfg_d.pulse_kick = scale_pulse(period_q, duty_w);
        end
        CFG_PHASE_OFFSET: cfg_d.phase_offset = off_w;
        CFG_REVERSE: cfg_d.reverse = cfg_wdata_i[0];
        CFG_TIMER_PERIOD: begin
          period_d = cfg_wdata_i;
          cfg_d.pulse_run = scale_pulse(cfg_wdata_i, cfg_q.run_duty);
          cfg_d.pulse_kick = scale_pulse(cfg_wdata_i, cfg_q.kick_duty);
        end
        CFG_KICK_INTERVAL: cfg_d.kick_interval = cfg_wdata_i;
        CFG_KICK_STEP_LIMIT: cfg_d.kick_step_limit = cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{run_duty: RunDutyRst, kick_duty: KickDutyRst,
                 phase_offset: PhaseOffsetRst, reverse: ReverseRst,
                 kick_interval: KickIntervalRst, kick_step_limit: KickStepLimitRst,
                 pulse_run: PulseRunRst, pulse_kick: PulseKickRst};
      period_q <= TimerPeriodRst;
    end else begin
      cfg_q <= cfg_d;
      period_q <= period_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire
